// ===== rtl/dmsr_pkg.sv =====
package dmsr_pkg;

    localparam int unsigned SPEED_W    = 7;
    localparam int unsigned DUTY_W     = 8;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned INTERVAL_W = 16;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [SPEED_W-1:0] SPEED_MAX = 7'd100;
    localparam logic [SPEED_W-1:0] STEP_MIN  = 7'd1;

    localparam logic [SPEED_W-1:0]    RESET_RAMP_STEP     = 7'd5;
    localparam logic [INTERVAL_W-1:0] RESET_RAMP_INTERVAL = 16'd40;
    localparam logic [SPEED_W-1:0]    RESET_RISE_FLOOR    = 7'd0;
    localparam logic [SPEED_W-1:0]    RESET_FALL_FLOOR    = 7'd0;

    // floor(s * 51 / 20) == (s * 167127) >> 16 for s in 0..100
    localparam int unsigned        DUTY_RECIP_W = 18;
    localparam logic [DUTY_RECIP_W-1:0] DUTY_RECIP = 18'd167127;
    localparam int unsigned        DUTY_SHIFT   = 16;
    localparam int unsigned        DUTY_PROD_W  = SPEED_W + DUTY_RECIP_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RAMP_STEP     = 2'd0,
        CFG_RAMP_INTERVAL = 2'd1,
        CFG_RISE_FLOOR    = 2'd2,
        CFG_FALL_FLOOR    = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic [SPEED_W-1:0]    ramp_step;
        logic [INTERVAL_W-1:0] ramp_interval;
        logic [SPEED_W-1:0]    rise_floor;
        logic [SPEED_W-1:0]    fall_floor;
    } t_cfg;

    typedef struct packed {
        logic [TIME_W-1:0]  time_ms;
        logic               left_run;
        logic               left_ahead;
        logic [SPEED_W-1:0] left_goal;
        logic               right_run;
        logic               right_ahead;
        logic [SPEED_W-1:0] right_goal;
    } t_in_word;

    typedef struct packed {
        logic [DUTY_W-1:0] left_duty;
        logic              left_pwm_on;
        logic              left_dir_pin;
        logic [DUTY_W-1:0] right_duty;
        logic              right_pwm_on;
        logic              right_dir_pin;
    } t_out_word;

    typedef struct packed {
        logic               run;
        logic               ahead;
        logic [SPEED_W-1:0] goal;
    } t_motor_cmd;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic              pwm_on;
        logic              dir_pin;
    } t_motor_out;

endpackage

// ===== rtl/dmsr_motor.sv =====
module dmsr_motor (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_fire,
    input  logic [dmsr_pkg::TIME_W-1:0]     i_time_ms,
    input  dmsr_pkg::t_motor_cmd            i_cmd,
    input  dmsr_pkg::t_cfg                  i_cfg,
    output dmsr_pkg::t_motor_out            o_res
);

    logic [dmsr_pkg::SPEED_W-1:0] r_speed;
    logic                         r_fwd;
    logic                         r_started;
    logic [dmsr_pkg::TIME_W-1:0]  r_start;

    logic [dmsr_pkg::SPEED_W-1:0]     goal_c;
    logic [dmsr_pkg::SPEED_W-1:0]     step;
    logic [dmsr_pkg::SPEED_W-1:0]     rfl;
    logic [dmsr_pkg::SPEED_W-1:0]     target;
    logic                             active;
    logic                             n_fwd;
    logic [dmsr_pkg::TIME_W-1:0]      elapsed;
    logic                             done;
    logic [dmsr_pkg::SPEED_W:0]       sp_plus;
    logic [dmsr_pkg::SPEED_W:0]       tgt_plus;
    logic                             go_up;
    logic                             go_down;
    logic                             change;
    logic [dmsr_pkg::SPEED_W-1:0]     next_speed;
    logic [dmsr_pkg::SPEED_W-1:0]     n_speed;
    logic [dmsr_pkg::DUTY_PROD_W-1:0] duty_prod;

    always_comb begin
        goal_c = (i_cmd.goal > dmsr_pkg::SPEED_MAX) ? dmsr_pkg::SPEED_MAX : i_cmd.goal;
        step   = (i_cfg.ramp_step == '0) ? dmsr_pkg::STEP_MIN : i_cfg.ramp_step;
        rfl    = (i_cfg.rise_floor > dmsr_pkg::SPEED_MAX) ? dmsr_pkg::SPEED_MAX
                                                          : i_cfg.rise_floor;
        n_fwd  = r_fwd;
        if (!i_cmd.run) begin
            active = (r_speed != '0);
            target = '0;
        end else begin
            active = 1'b1;
            if (i_cmd.ahead != r_fwd) begin
                if (r_speed != '0) begin
                    target = '0;
                end else begin
                    n_fwd  = i_cmd.ahead;
                    target = goal_c;
                end
            end else begin
                target = goal_c;
            end
        end

        elapsed  = i_time_ms - r_start;
        done     = !r_started
                   || (elapsed >= {{(dmsr_pkg::TIME_W-dmsr_pkg::INTERVAL_W){1'b0}},
                                   i_cfg.ramp_interval});
        sp_plus  = {1'b0, r_speed} + {1'b0, step};
        tgt_plus = {1'b0, target} + {1'b0, step};
        go_up    = {1'b0, target} >= sp_plus;
        go_down  = tgt_plus <= {1'b0, r_speed};

        change     = 1'b0;
        next_speed = r_speed;
        if (done && active) begin
            priority if (go_up) begin
                change     = 1'b1;
                next_speed = (r_speed < rfl) ? rfl : sp_plus[dmsr_pkg::SPEED_W-1:0];
            end else if (go_down) begin
                change     = 1'b1;
                next_speed = (r_speed <= i_cfg.fall_floor) ? '0 : (r_speed - step);
            end else begin
                change     = (target != r_speed);
                next_speed = target;
            end
        end
        n_speed = next_speed;

        duty_prod = {{dmsr_pkg::DUTY_RECIP_W{1'b0}}, n_speed}
                    * {{dmsr_pkg::SPEED_W{1'b0}}, dmsr_pkg::DUTY_RECIP};
        o_res.duty    = duty_prod[dmsr_pkg::DUTY_SHIFT +: dmsr_pkg::DUTY_W];
        o_res.pwm_on  = (n_speed != '0);
        o_res.dir_pin = n_fwd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed   <= '0;
            r_fwd     <= 1'b1;
            r_started <= 1'b0;
            r_start   <= '0;
        end else if (i_fire) begin
            r_fwd <= n_fwd;
            if (change) begin
                r_speed   <= n_speed;
                r_start   <= i_time_ms;
                r_started <= 1'b1;
            end
        end
    end

endmodule

// ===== rtl/dual_motor_speed_ramp.sv =====
// Two-motor PWM speed ramp. Each input word carries a millisecond timestamp and, per motor,
// run, direction and target speed; each word yields exactly one output word with duty
// (floor of speed * 2.55), PWM enable and direction pin. Speed changes at most once per
// ramp_interval ms: by ramp_step, straight up to rise_floor, to zero at or below fall_floor,
// or to a nearer target. A direction change ramps to zero before the pin flips. Rate is
// one word per cycle while the output is not stalled: a word is held in the input register,
// the per-motor step logic and duty multiplier then load the output register, and a
// stalled output still lets one further word in. Write configuration only while idle.
module dual_motor_speed_ramp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  dmsr_pkg::t_in_word                i_in_word,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output dmsr_pkg::t_out_word               o_out_word,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [dmsr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [dmsr_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    dmsr_pkg::t_cfg       r_cfg;
    dmsr_pkg::t_in_word   r_in_word;
    logic                 r_in_valid;
    dmsr_pkg::t_out_word  r_out_word;
    logic                 r_out_valid;

    logic                 advance;
    logic                 fire;
    dmsr_pkg::t_motor_cmd left_cmd;
    dmsr_pkg::t_motor_cmd right_cmd;
    dmsr_pkg::t_motor_out left_res;
    dmsr_pkg::t_motor_out right_res;
    dmsr_pkg::t_out_word  n_out_word;

    assign advance     = !r_out_valid || i_out_ready;
    assign fire        = r_in_valid && advance;
    assign o_in_ready  = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        left_cmd.run    = r_in_word.left_run;
        left_cmd.ahead  = r_in_word.left_ahead;
        left_cmd.goal   = r_in_word.left_goal;
        right_cmd.run   = r_in_word.right_run;
        right_cmd.ahead = r_in_word.right_ahead;
        right_cmd.goal  = r_in_word.right_goal;

        n_out_word.left_duty     = left_res.duty;
        n_out_word.left_pwm_on   = left_res.pwm_on;
        n_out_word.left_dir_pin  = left_res.dir_pin;
        n_out_word.right_duty    = right_res.duty;
        n_out_word.right_pwm_on  = right_res.pwm_on;
        n_out_word.right_dir_pin = right_res.dir_pin;
    end

    dmsr_motor u_left (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_time_ms (r_in_word.time_ms),
        .i_cmd     (left_cmd),
        .i_cfg     (r_cfg),
        .o_res     (left_res)
    );

    dmsr_motor u_right (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_time_ms (r_in_word.time_ms),
        .i_cmd     (right_cmd),
        .i_cfg     (r_cfg),
        .o_res     (right_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ramp_step     <= dmsr_pkg::RESET_RAMP_STEP;
            r_cfg.ramp_interval <= dmsr_pkg::RESET_RAMP_INTERVAL;
            r_cfg.rise_floor    <= dmsr_pkg::RESET_RISE_FLOOR;
            r_cfg.fall_floor    <= dmsr_pkg::RESET_FALL_FLOOR;
        end else if (i_cfg_valid) begin
            unique case (dmsr_pkg::t_cfg_index'(i_cfg_index))
                dmsr_pkg::CFG_RAMP_STEP: begin
                    r_cfg.ramp_step <= i_cfg_data[dmsr_pkg::SPEED_W-1:0];
                end
                dmsr_pkg::CFG_RAMP_INTERVAL: begin
                    r_cfg.ramp_interval <= i_cfg_data[dmsr_pkg::INTERVAL_W-1:0];
                end
                dmsr_pkg::CFG_RISE_FLOOR: begin
                    r_cfg.rise_floor <= i_cfg_data[dmsr_pkg::SPEED_W-1:0];
                end
                dmsr_pkg::CFG_FALL_FLOOR: begin
                    r_cfg.fall_floor <= i_cfg_data[dmsr_pkg::SPEED_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_word <= i_in_word;
        end
        if (fire) begin
            r_out_word <= n_out_word;
        end
    end

endmodule
